// ===== rtl/core/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and helpers for the horizontal blur scaler
// Pixel and weight widths, register codes, the blend request type and the
// per-channel scaling and clamped add functions.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int unsigned PixW    = 24;
  localparam int unsigned ChW     = 8;
  localparam int unsigned NumCh   = PixW / ChW;
  localparam int unsigned WtW     = 9;
  localparam int unsigned AlphaW  = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 9;

  // full weight: channel passes unchanged
  localparam logic [WtW-1:0] WtFull = 9'd256;
  localparam logic [ChW-1:0] ChMax  = 8'hFF;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgBlurAlpha = 2'd0,
    CfgWidthMode = 2'd1
  } cfg_idx_e;

  // one output pixel: wx*x + wc*c + wy*y, per channel
  typedef struct packed {
    logic [PixW-1:0] x;
    logic [PixW-1:0] c;
    logic [PixW-1:0] y;
    logic [WtW-1:0]  wx;
    logic [WtW-1:0]  wc;
    logic [WtW-1:0]  wy;
  } blend_op_t;

  // floor(ch * w / 256), w at most 256
  function automatic logic [ChW-1:0] scale_ch(input logic [ChW-1:0] ch,
                                              input logic [WtW-1:0] w);
    logic [ChW+WtW-1:0] prod;
    begin
      prod = {{WtW{1'b0}}, ch} * {{ChW{1'b0}}, w};
      scale_ch = prod[ChW+ChW-1:ChW];
    end
  endfunction

  // channel add, clamped at full scale
  function automatic logic [ChW-1:0] add_ch(input logic [ChW-1:0] a,
                                            input logic [ChW-1:0] b);
    logic [ChW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      add_ch = s[ChW] ? ChMax : s[ChW-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/hbs_blend.sv =====
// ----------------------------------------------------------------------------
// hbs_blend: three-tap weighted pixel blend
// Scales three RGB888 pixels per channel and sums the terms with clamping.
// ----------------------------------------------------------------------------
module hbs_blend import hbs_pkg::*; (
  input  blend_op_t       op_i,
  output logic [PixW-1:0] pixel_o
);

  // per channel: clamp(clamp(x term + c term) + y term)
  always_comb begin
    logic [ChW-1:0] tx, tc, ty, s1;
    pixel_o = '0;
    for (int k = 0; k < NumCh; k++) begin
      tx = scale_ch(op_i.x[k*ChW +: ChW], op_i.wx);
      tc = scale_ch(op_i.c[k*ChW +: ChW], op_i.wc);
      ty = scale_ch(op_i.y[k*ChW +: ChW], op_i.wy);
      s1 = add_ch(tx, tc);
      pixel_o[k*ChW +: ChW] = add_ch(s1, ty);
    end
  end

endmodule

// ===== rtl/core/horizontal_blur_scaler_core.sv =====
// ----------------------------------------------------------------------------
// horizontal_blur_scaler_core: horizontal blur with optional width doubling
// RGB888 line filter; previous and current pixel are held, results lag one
// input and the end-of-line pixel flushes the line.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i in_ready_o in_pixel_i line_end_i | sink
//  out     | out_valid_o out_ready_i out_pixel_o out_line_end_o | source
//  cfg     | cfg_we_i cfg_idx_i cfg_wdata_i            | write only
//
// One output pixel per cycle leaves the result register while out_ready_i
// allows. A request emits the held pixel, if one is held; line end adds an
// emit for the last pixel, and doubling mode gives a left and a right pixel
// per emit. A job register and the result register decouple the sides, so
// a new request is taken in the cycle the previous job issues its last pixel.
// Reset clears line state, configuration and valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module horizontal_blur_scaler_core import hbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  // input pixels
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PixW-1:0]    in_pixel_i,
  input  logic               line_end_i,
  // output pixels
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PixW-1:0]    out_pixel_o,
  output logic               out_line_end_o
);

  // configuration registers
  logic [AlphaW-1:0] alpha_q;
  logic              mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgBlurAlpha: alpha_q <= cfg_wdata_i[AlphaW-1:0];
        CfgWidthMode: mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // line state
  logic [PixW-1:0] prev_q, curr_q, prev_d, curr_d;
  logic            holding_q;

  // job register: sel_q picks the held emit (0) or the end-of-line emit (1)
  logic            job_v_q, e1_v_q;
  logic [PixW-1:0] p0_q, c0_q, n0_q, p1_q, c1_q;
  logic            sel_q, half_q;

  // result register
  logic            out_v_q, out_last_q;
  logic [PixW-1:0] out_pix_q;

  logic in_acc, out_load, advance, op_last, job_new_v;

  assign out_load   = !out_v_q || out_ready_i;
  assign advance    = job_v_q && out_load;
  assign op_last    = (half_q || mode_q) && (sel_q || !e1_v_q);
  assign in_ready_o = !job_v_q || (advance && op_last);
  assign in_acc     = in_valid_i && in_ready_o;
  assign job_new_v  = holding_q || line_end_i;

  // neighbor update on accept
  always_comb begin
    if (holding_q) begin
      prev_d = curr_q;
      curr_d = in_pixel_i;
    end else begin
      prev_d = in_pixel_i;
      curr_d = in_pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      curr_q    <= '0;
      holding_q <= 1'b0;
    end else if (in_acc) begin
      prev_q    <= prev_d;
      curr_q    <= curr_d;
      holding_q <= !line_end_i;
    end
  end

  // job control and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      e1_v_q  <= 1'b0;
      sel_q   <= 1'b0;
      half_q  <= 1'b0;
    end else if (in_acc) begin
      job_v_q <= job_new_v;
      e1_v_q  <= line_end_i;
      sel_q   <= !holding_q;
      half_q  <= 1'b0;
    end else if (advance) begin
      if (op_last) begin
        job_v_q <= 1'b0;
      end else if (!mode_q && !half_q) begin
        half_q <= 1'b1;
      end else begin
        sel_q  <= 1'b1;
        half_q <= 1'b0;
      end
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p0_q <= prev_q;
      c0_q <= curr_q;
      n0_q <= in_pixel_i;
      p1_q <= prev_d;
      c1_q <= curr_d;
    end
  end

  // build the blend request for the current output pixel
  logic [WtW-1:0]  w_c1, w_c2_dbl, w_c2_tap;
  logic [PixW-1:0] op_p, op_c, op_n, blend_pix;
  blend_op_t       op;
  logic            op_eol;

  assign w_c1     = {2'b00, alpha_q[AlphaW-1:2]};
  assign w_c2_dbl = WtFull - w_c1;
  assign w_c2_tap = WtFull - {1'b0, alpha_q[AlphaW-1:1]};

  assign op_p = sel_q ? p1_q : p0_q;
  assign op_c = sel_q ? c1_q : c0_q;
  assign op_n = sel_q ? c1_q : n0_q;

  always_comb begin
    op.x   = op_p;
    op.c   = op_c;
    op.y   = op_n;
    op.wx  = w_c1;
    op.wc  = w_c2_dbl;
    op.wy  = '0;
    op_eol = 1'b0;
    if (mode_q) begin
      // three-tap, width kept
      op.wc  = w_c2_tap;
      op.wy  = w_c1;
      op_eol = sel_q;
    end else if (half_q) begin
      if (sel_q) begin
        // last pixel of the line passes unchanged
        op.wx  = '0;
        op.wc  = WtFull;
        op_eol = 1'b1;
      end else begin
        op.x = op_n;
      end
    end
  end

  hbs_blend u_blend (
    .op_i    (op),
    .pixel_o (blend_pix)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= job_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pix_q  <= blend_pix;
      out_last_q <= op_eol;
    end
  end

  assign out_valid_o    = out_v_q;
  assign out_pixel_o    = out_pix_q;
  assign out_line_end_o = out_last_q;

endmodule

// ===== test/horizontal_blur_scaler_core_tb.sv =====
// ----------------------------------------------------------------------------
// horizontal_blur_scaler_core_tb: self-checking bench for the blur scaler
// Sends RGB888 line pixels through the core in both width modes at many blur
// strengths. A line tracker predicts the blended output pixels and compares
// them in order, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module horizontal_blur_scaler_core_tb import hbs_pkg::*;;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseItems   = 40;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned HoldAfter    = 70;
  localparam int unsigned IdlePct      = 19;

  // register indexes that decode to nothing
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam logic [PixW-1:0] PxBlack = 24'h000000;
  localparam logic [PixW-1:0] PxWhite = 24'hFFFFFF;

  typedef struct packed {
    logic [PixW-1:0] px;
    logic            eol;
  } out_pix_t;

  // Tracks line state and register copies, predicts output pixels
  class line_blur_tracker;
    logic [AlphaW-1:0] alpha;
    logic              keep_width;
    logic [PixW-1:0]   left_px;
    logic [PixW-1:0]   mid_px;
    bit                have_px;
    out_pix_t          awaited_px[$];
    int unsigned       errors;

    function new();
      alpha      = '0;
      keep_width = 1'b0;
      left_px    = '0;
      mid_px     = '0;
      have_px    = 1'b0;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
      if (idx == CfgBlurAlpha) begin
        alpha = val[AlphaW-1:0];
      end else if (idx == CfgWidthMode) begin
        keep_width = val[0];
      end
    endtask

    // floor(ch * w / 256) on every channel
    function logic [PixW-1:0] weigh(logic [PixW-1:0] px, int unsigned w);
      logic [PixW-1:0] r;
      for (int i = 0; i < NumCh; i++) begin
        r[i*ChW +: ChW] = 8'((int'(px[i*ChW +: ChW]) * w) >> 8);
      end
      return r;
    endfunction

    // channel sum, clamped at full scale
    function logic [PixW-1:0] mix(logic [PixW-1:0] a, logic [PixW-1:0] b);
      logic [PixW-1:0] r;
      int unsigned     s;
      for (int i = 0; i < NumCh; i++) begin
        s = int'(a[i*ChW +: ChW]) + int'(b[i*ChW +: ChW]);
        r[i*ChW +: ChW] = (s > 255) ? 8'hFF : s[ChW-1:0];
      end
      return r;
    endfunction

    task queue_px(logic [PixW-1:0] px, logic eol);
      out_pix_t e;
      e.px  = px;
      e.eol = eol;
      awaited_px.push_back(e);
    endtask

    // output pixels of cur with neighbours p and nx
    task blend(logic [PixW-1:0] p, logic [PixW-1:0] cur, logic [PixW-1:0] nx,
               logic last);
      int unsigned     a;
      int unsigned     c1;
      logic [PixW-1:0] centre;
      a  = 32'(alpha);
      c1 = a / 4;
      if (!keep_width) begin
        centre = weigh(cur, 256 - c1);
        queue_px(mix(weigh(p, c1), centre), 1'b0);
        if (last) begin
          queue_px(cur, 1'b1);
        end else begin
          queue_px(mix(weigh(nx, c1), centre), 1'b0);
        end
      end else begin
        queue_px(mix(mix(weigh(p, c1), weigh(cur, 256 - a / 2)), weigh(nx, c1)),
                 last);
      end
    endtask

    task note_request(logic [PixW-1:0] px, logic eol);
      if (!have_px) begin
        left_px = px;
        mid_px  = px;
      end else begin
        blend(left_px, mid_px, px, 1'b0);
        left_px = mid_px;
        mid_px  = px;
      end
      if (eol) begin
        blend(left_px, mid_px, mid_px, 1'b1);
        have_px = 1'b0;
      end else begin
        have_px = 1'b1;
      end
    endtask

    task check_result(logic [PixW-1:0] px, logic eol);
      out_pix_t e;
      if (awaited_px.size() == 0) begin
        report($sformatf("unexpected pixel %06h eol %0b", px, eol));
      end else begin
        e = awaited_px.pop_front();
        if (px !== e.px) begin
          report($sformatf("pixel %06h, predicted %06h", px, e.px));
        end
        if (eol !== e.eol) begin
          report($sformatf("eol %0b, predicted %0b (pixel %06h)", eol, e.eol, px));
        end
      end
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgDatW-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [PixW-1:0]    in_pixel_i  = '0;
  logic               line_end_i  = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [PixW-1:0]    out_pixel_o;
  logic               out_line_end_o;

  line_blur_tracker blur = new();

  int unsigned cycle_count    = 0;
  int unsigned requests_taken = 0;
  int unsigned hold_left      = 0;
  bit          squeezed       = 1'b0;
  bit          steady         = 1'b0;

  horizontal_blur_scaler_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_pixel_i     (in_pixel_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_pixel_o    (out_pixel_o),
    .out_line_end_o (out_line_end_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d pixels still awaited",
               cycle_count, blur.awaited_px.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output side: check accepted pixels, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      blur.check_result(out_pixel_o, out_line_end_o);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!squeezed && requests_taken >= HoldAfter) begin
      // long stall so the core backs up into its input
      squeezed  = 1'b1;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IdlePct);
    end
  end

  function automatic logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] px;
    for (int i = 0; i < NumCh; i++) begin
      case ($urandom_range(7))
        0:       px[i*ChW +: ChW] = 8'h00;
        1:       px[i*ChW +: ChW] = 8'hFF;
        default: px[i*ChW +: ChW] = 8'($urandom_range(255));
      endcase
    end
    return px;
  endfunction

  function automatic logic [CfgDatW-1:0] rand_alpha();
    case ($urandom_range(4))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd511;
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  // One register write; enable drops again after the clock edge that takes the write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDatW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    blur.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one pixel request, with random idle cycles ahead of it
  task automatic send_pixel(input logic [PixW-1:0] px, input logic eol);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(99) < IdlePct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    line_end_i <= eol;
    do @(posedge clk_i); while (!in_ready_o);
    blur.note_request(px, eol);
    requests_taken++;
  endtask

  // Stop offering, wait for all predicted pixels, then let the core go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (blur.awaited_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned     sent;
    int unsigned     len;
    bit              keep_open;
    bit              last_line;
    logic [PixW-1:0] px;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no blur, doubling. One- and two-pixel lines.
    send_pixel(PxWhite, 1'b1);
    send_pixel(PxBlack, 1'b0);
    send_pixel(PxWhite, 1'b1);
    settle();

    // Full blur strength, doubling
    write_reg(CfgBlurAlpha, 9'd256);
    write_reg(CfgWidthMode, 9'd0);
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'h0000FF, 1'b1);
    settle();

    // Alpha above 256, three-tap mode
    write_reg(CfgWidthMode, 9'd1);
    write_reg(CfgBlurAlpha, 9'd511);
    send_pixel(24'h123456, 1'b1);
    send_pixel(PxWhite, 1'b0);
    send_pixel(PxBlack, 1'b0);
    send_pixel(PxWhite, 1'b1);
    send_pixel(PxWhite, 1'b0);
    send_pixel(PxWhite, 1'b1);
    // leave a line open, then change settings mid-line
    send_pixel(24'hAAAAAA, 1'b0);
    send_pixel(24'h555555, 1'b0);
    settle();
    write_reg(CfgBlurAlpha, 9'd256);
    write_reg(CfgSpareA, 9'h1FF);
    write_reg(CfgSpareB, 9'h0AB);
    send_pixel(24'h0F0F0F, 1'b1);
    send_pixel(24'hC3C3C3, 1'b0);
    settle();
    write_reg(CfgWidthMode, 9'd0);
    send_pixel(24'h3C3C3C, 1'b1);
    settle();

    // Random lines, fresh settings per phase
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(CfgBlurAlpha, rand_alpha());
      write_reg(CfgWidthMode,
                {8'd0, (ph < 2) ? ph[0] : 1'($urandom_range(1))});
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? CfgSpareA : CfgSpareB, 9'($urandom_range(511)));
      end
      steady    = (ph == 3);
      keep_open = ph[0];
      sent      = 0;
      while (sent < PhaseItems) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(6, 1);
        last_line = (sent + len >= PhaseItems);
        for (int k = 0; k < len; k++) begin
          px = rand_pixel();
          send_pixel(px, (k == len - 1) && !(last_line && keep_open));
        end
        sent += len;
      end
      settle();
    end
    steady = 1'b0;

    if (blur.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hbs_pkg.sv
rtl/core/hbs_blend.sv
rtl/core/horizontal_blur_scaler_core.sv
test/horizontal_blur_scaler_core_tb.sv
